[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bte_pkg.sv]
// ----------------------------------------------------------------------------
// bte_pkg
// Types, constants and fixed-point helpers of the Bezier trajectory evaluator
// ----------------------------------------------------------------------------
package bte_pkg;

    localparam int JOINTS  = 10;
    localparam int NCOEF   = 6;
    localparam int ADDR_W  = $clog2(JOINTS * NCOEF);
    localparam int JW      = 4;
    localparam int PROD_W  = 52;
    localparam int ACC_W   = 48;
    localparam int OPA_W   = 30;
    localparam int OPB_W   = 22;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef struct packed {
        logic              action;
        logic [3:0]        joint_sel;
        logic [2:0]        coef_index;
        logic signed [23:0] coef_value;
        logic [16:0]       tau;
    } cmd_t;

    typedef struct packed {
        logic [3:0]         joint_out;
        logic signed [23:0] position;
        logic signed [31:0] velocity;
        logic               last;
    } res_t;

    typedef struct packed {
        logic signed [OPA_W-1:0] a;
        logic signed [OPB_W-1:0] b;
    } mul_req_t;

    // binomial weights, degree 5 (sel 0) or degree 4 (sel 1)
    function automatic logic [3:0] binom(input logic sel, input logic [2:0] j);
        logic [3:0] r;
        r = 4'd0;
        case (j)
            3'd0: r = 4'd1;
            3'd1: r = sel ? 4'd4 : 4'd5;
            3'd2: r = sel ? 4'd6 : 4'd10;
            3'd3: r = sel ? 4'd4 : 4'd10;
            3'd4: r = sel ? 4'd1 : 4'd5;
            3'd5: r = sel ? 4'd0 : 4'd1;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // round half up from Q32 to Q16
    function automatic logic signed [PROD_W-1:0] rnd_q16(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] s;
        s = x + 52'sd32768;
        return s >>> 16;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [PROD_W-1:0] x);
        logic signed [23:0] r;
        if (x > 52'sd8388607)
            r = 24'sh7FFFFF;
        else if (x < -52'sd8388608)
            r = 24'sh800000;
        else
            r = x[23:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
        logic signed [31:0] r;
        if (x > 52'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (x < -52'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

[src/bezier_trajectory_eval_top.sv]
// ----------------------------------------------------------------------------
// bezier_trajectory_eval_top
// Degree-5 Bezier position and velocity for every joint, one shared multiplier
// ----------------------------------------------------------------------------
//  channel   signals                         handshake
//  command   start, busy, cmd                taken when start and not busy
//  result    result_valid, result            one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_wdata               written when cfg_we is high
//
//  A load item with an in-range address is written to the table when taken. An evaluate item
//  keeps busy high while the sequencer forms the tau powers, then the basis
//  weights, then each joint in turn, all on the single shared multiplier.
//  Results come one per joint; busy falls with the last one.
//  rst_n clears the sequencer and restores inv_reg; the table is
//  undefined until loaded. The receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
module bezier_trajectory_eval_top
    import bte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata,
    output logic        result_valid,
    output res_t        result
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_POW_M  = 12'b0000_0000_0010,
        ST_POW_W  = 12'b0000_0000_0100,
        ST_WGT_M1 = 12'b0000_0000_1000,
        ST_WGT_M2 = 12'b0000_0001_0000,
        ST_WGT_W  = 12'b0000_0010_0000,
        ST_RD     = 12'b0000_0100_0000,
        ST_MB     = 12'b0000_1000_0000,
        ST_ME     = 12'b0001_0000_0000,
        ST_AE     = 12'b0010_0000_0000,
        ST_DR     = 12'b0100_0000_0000,
        ST_VM     = 12'b1000_0000_0000
    } state_t;

    // the output step is a separate flag beside the state register, raised as the state returns to idle
    logic vo_reg, vo_next;

    state_t             state_reg, state_next;
    logic [2:0]         k_reg, k_next;
    logic               s_reg, s_next;
    logic               dsel_reg, dsel_next;
    logic [JW-1:0]      jnt_reg, jnt_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               out_valid_reg, out_valid_next;
    logic [19:0]        inv_reg;

    logic signed [23:0] coef_mem [JOINTS*NCOEF];

    logic [16:0]        t_reg, u_reg;
    logic [16:0]        tp_reg [NCOEF];
    logic [16:0]        up_reg [NCOEF];
    logic [17:0]        b_reg [NCOEF];
    logic signed [18:0] e_reg [NCOEF];
    logic [17:0]        dprev_reg;
    logic [17:0]        wb_reg;
    logic signed [18:0] we_reg;
    logic signed [23:0] rdata_reg;
    logic signed [ACC_W-1:0] pos_acc_reg, der_acc_reg;
    logic signed [OPA_W-1:0] derq_reg;
    res_t               res_reg;

    mul_req_t                 mreq;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_rnd, pos_rnd, der_rnd;
    logic signed [ACC_W-1:0]  p48;
    logic [16:0]              tau_c;
    logic [2:0]               km1, upi, ld_idx;
    logic                     rd_en, accept, last_jnt;
    logic [ADDR_W-1:0]        ld_addr;
    logic                     ld_ok;

    assign accept   = start && (state_reg == ST_IDLE) && !vo_reg;
    assign busy     = (state_reg != ST_IDLE) || vo_reg;
    assign last_jnt = (jnt_reg == JW'(JOINTS - 1));
    assign tau_c    = (cmd.tau > ONE_Q16) ? ONE_Q16 : cmd.tau;
    assign km1      = k_reg - 3'd1;
    assign upi      = dsel_reg ? (3'd4 - k_reg) : (3'd5 - k_reg);
    assign ld_idx   = (state_reg == ST_RD) ? 3'd0 : (k_reg + 3'd1);
    assign rd_en    = (state_reg == ST_RD) || ((state_reg == ST_AE) && (k_reg != 3'd5));
    assign p48      = prod[ACC_W-1:0];
    assign prod_rnd = rnd_q16(prod);
    assign pos_rnd  = rnd_q16({{(PROD_W-ACC_W){pos_acc_reg[ACC_W-1]}}, pos_acc_reg});
    assign der_rnd  = rnd_q16({{(PROD_W-ACC_W){der_acc_reg[ACC_W-1]}}, der_acc_reg});
    assign ld_ok    = (int'(cmd.joint_sel) < JOINTS) && (int'(cmd.coef_index) < NCOEF);
    assign ld_addr  = ADDR_W'(cmd.joint_sel) * ADDR_W'(NCOEF) + ADDR_W'(cmd.coef_index);

    // shared multiplier
    bte_mul u_mul (
        .clk  (clk),
        .req  (mreq),
        .prod (prod)
    );

    // multiplier operand selection
    always_comb
    begin
        mreq.a = '0;
        mreq.b = '0;
        case (state_reg)
            ST_POW_M:
            begin
                mreq.a = s_reg ? $signed({13'd0, up_reg[km1]}) : $signed({13'd0, tp_reg[km1]});
                mreq.b = s_reg ? $signed({5'd0, u_reg}) : $signed({5'd0, t_reg});
            end
            ST_WGT_M1:
            begin
                mreq.a = $signed({13'd0, tp_reg[k_reg]});
                mreq.b = $signed({18'd0, binom(dsel_reg, k_reg)});
            end
            ST_WGT_M2:
            begin
                mreq.a = prod[OPA_W-1:0];
                mreq.b = $signed({5'd0, up_reg[upi]});
            end
            ST_MB:
            begin
                mreq.a = {{(OPA_W-24){rdata_reg[23]}}, rdata_reg};
                mreq.b = $signed({4'd0, wb_reg});
            end
            ST_ME:
            begin
                mreq.a = {{(OPA_W-24){rdata_reg[23]}}, rdata_reg};
                mreq.b = {{(OPB_W-19){we_reg[18]}}, we_reg};
            end
            ST_VM:
            begin
                mreq.a = derq_reg;
                mreq.b = $signed({2'd0, inv_reg});
            end
            default:
            begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        s_next         = s_reg;
        dsel_next      = dsel_reg;
        jnt_next       = jnt_reg;
        addr_next      = addr_reg;
        out_valid_next = 1'b0;
        vo_next        = 1'b0;
        if (vo_reg)
        begin
            // emit one joint, then the next joint or idle
            out_valid_next = 1'b1;
            if (last_jnt)
                state_next = ST_IDLE;
            else
            begin
                jnt_next   = jnt_reg + JW'(1);
                k_next     = 3'd0;
                state_next = ST_RD;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && cmd.action == ACT_EVAL)
                    begin
                        state_next = ST_POW_M;
                        k_next     = 3'd1;
                        s_next     = 1'b0;
                    end
                end
                ST_POW_M:
                    state_next = ST_POW_W;
                ST_POW_W:
                begin
                    if (!s_reg)
                    begin
                        s_next     = 1'b1;
                        state_next = ST_POW_M;
                    end
                    else if (k_reg == 3'd5)
                    begin
                        s_next     = 1'b0;
                        k_next     = 3'd0;
                        dsel_next  = 1'b0;
                        state_next = ST_WGT_M1;
                    end
                    else
                    begin
                        s_next     = 1'b0;
                        k_next     = k_reg + 3'd1;
                        state_next = ST_POW_M;
                    end
                end
                ST_WGT_M1:
                    state_next = ST_WGT_M2;
                ST_WGT_M2:
                    state_next = ST_WGT_W;
                ST_WGT_W:
                begin
                    if (!dsel_reg && k_reg == 3'd5)
                    begin
                        dsel_next  = 1'b1;
                        k_next     = 3'd0;
                        state_next = ST_WGT_M1;
                    end
                    else if (dsel_reg && k_reg == 3'd4)
                    begin
                        jnt_next   = '0;
                        addr_next  = '0;
                        k_next     = 3'd0;
                        state_next = ST_RD;
                    end
                    else
                    begin
                        k_next     = k_reg + 3'd1;
                        state_next = ST_WGT_M1;
                    end
                end
                ST_RD:
                begin
                    addr_next  = addr_reg + ADDR_W'(1);
                    state_next = ST_MB;
                end
                ST_MB:
                    state_next = ST_ME;
                ST_ME:
                    state_next = ST_AE;
                ST_AE:
                begin
                    if (k_reg == 3'd5)
                        state_next = ST_DR;
                    else
                    begin
                        k_next     = k_reg + 3'd1;
                        addr_next  = addr_reg + ADDR_W'(1);
                        state_next = ST_MB;
                    end
                end
                ST_DR:
                    state_next = ST_VM;
                ST_VM:
                begin
                    vo_next    = 1'b1;
                    state_next = ST_IDLE;
                end
                default:
                    state_next = ST_IDLE;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            s_reg         <= 1'b0;
            dsel_reg      <= 1'b0;
            jnt_reg       <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            vo_reg        <= 1'b0;
            inv_reg       <= 20'd163840;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            s_reg         <= s_next;
            dsel_reg      <= dsel_next;
            jnt_reg       <= jnt_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            vo_reg        <= vo_next;
            if (cfg_we)
                inv_reg <= cfg_wdata;
        end
    end

    // coefficient table, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (accept && cmd.action == ACT_LOAD && ld_ok)
            coef_mem[ld_addr] <= cmd.coef_value;
        if (rd_en)
            rdata_reg <= coef_mem[addr_reg];
    end

    // datapath: powers, weights, accumulators and result
    always_ff @(posedge clk)
    begin
        if (accept && cmd.action == ACT_EVAL)
        begin
            t_reg     <= tau_c;
            u_reg     <= ONE_Q16 - tau_c;
            tp_reg[0] <= ONE_Q16;
            up_reg[0] <= ONE_Q16;
            dprev_reg <= '0;
        end

        if (!vo_reg && state_reg == ST_POW_W)
        begin
            if (!s_reg)
                tp_reg[k_reg] <= prod_rnd[16:0];
            else
                up_reg[k_reg] <= prod_rnd[16:0];
        end

        // derivative weights stored as differences of neighbors
        if (!vo_reg && state_reg == ST_WGT_W)
        begin
            if (!dsel_reg)
                b_reg[k_reg] <= prod_rnd[17:0];
            else
            begin
                e_reg[k_reg] <= $signed({1'b0, dprev_reg}) - $signed({1'b0, prod_rnd[17:0]});
                dprev_reg    <= prod_rnd[17:0];
                if (k_reg == 3'd4)
                    e_reg[NCOEF-1] <= $signed({1'b0, prod_rnd[17:0]});
            end
        end

        if (!vo_reg && rd_en)
        begin
            wb_reg <= b_reg[ld_idx];
            we_reg <= e_reg[ld_idx];
        end

        if (!vo_reg && state_reg == ST_RD)
        begin
            pos_acc_reg <= '0;
            der_acc_reg <= '0;
        end

        if (!vo_reg && state_reg == ST_ME)
            pos_acc_reg <= pos_acc_reg + p48;

        // derivative terms carry the factor five
        if (!vo_reg && state_reg == ST_AE)
            der_acc_reg <= der_acc_reg + p48 + (p48 <<< 2);

        if (!vo_reg && state_reg == ST_DR)
            derq_reg <= der_rnd[OPA_W-1:0];

        if (vo_reg)
        begin
            res_reg.joint_out <= jnt_reg;
            res_reg.position  <= sat24(pos_rnd);
            res_reg.velocity  <= sat32(prod_rnd);
            res_reg.last      <= last_jnt;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = res_reg;

endmodule

[src/bte_mul.sv]
// ----------------------------------------------------------------------------
// bte_mul
// Shared signed multiplier with a registered product, one result per cycle
// ----------------------------------------------------------------------------
module bte_mul
    import bte_pkg::*;
(
    input  logic                     clk,
    input  mul_req_t                 req,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // product register
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(req.a * req.b);
    end

    assign prod = prod_reg;

endmodule

[src/bte_chk.sv]
// ----------------------------------------------------------------------------
// bte_chk
// Port-level checks of the Bezier trajectory evaluator, bound to the top
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bte_chk
    import bte_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input cmd_t cmd,
    input logic result_valid,
    input res_t result
);

    // an evaluate item keeps the block busy
    `ASSERT_NEXT(a_eval_busy, start && !busy && cmd.action == ACT_EVAL, busy, "eval item did not raise busy")

    // a load item produces nothing and leaves the block free
    `ASSERT_NEXT(a_load_quiet, start && !busy && cmd.action == ACT_LOAD, !busy && !result_valid, "load item caused activity")

    // busy falls exactly with the final joint
    `ASSERT_IMPL(a_last_idle, result_valid, busy == !result.last, "busy does not match last flag")

    // results never come in adjacent cycles
    `ASSERT_NEXT(a_strobe_gap, result_valid, !result_valid, "back-to-back result strobes")

    // the final result carries the highest joint
    `ASSERT_IMPL(a_last_joint, result_valid && result.last, result.joint_out == JW'(JOINTS - 1), "last flag on wrong joint")

endmodule

bind bezier_trajectory_eval_top bte_chk u_bte_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result)
);
